### sv/affine_gap_alignment_unit_macros.svh
// Assertion macros for the affine gap alignment unit.
// Each macro expands to one labelled concurrent assertion on clk, disabled in reset.
`ifndef AFFINE_GAP_ALIGNMENT_UNIT_MACROS_SVH
`define AFFINE_GAP_ALIGNMENT_UNIT_MACROS_SVH

// Same-cycle implication.
`define AGA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AGA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/aga_pkg.sv
// Package for the affine gap alignment unit: widths, score weights and codes.
// No dependencies.
package aga_pkg;

  localparam int MAX_LEN = 32;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = IDX_W + 1;
  localparam int SCORE_W = 18;
  localparam int SUM_W   = SCORE_W + 1;
  localparam int WT_W    = 4;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [WT_W-1:0]    weight_t;
  typedef logic [1:0]                code_t;

  // Weights in half units.
  localparam weight_t W_ZERO     = 4'sd0;
  localparam weight_t W_MATCH    = 4'sd2;
  localparam weight_t W_MISMATCH = -4'sd2;
  localparam weight_t W_NEW_GAP  = -4'sd4;
  localparam weight_t W_EXTEND   = -4'sd1;
  localparam score_t  W_FORBID   = -18'sd131070;

  // Input operation codes.
  localparam code_t FUNC_LOAD_A = 2'd0;
  localparam code_t FUNC_LOAD_B = 2'd1;
  localparam code_t FUNC_START  = 2'd2;

  // Traceback step codes.
  localparam code_t STEP_DIAG  = 2'd0;
  localparam code_t STEP_HORIZ = 2'd1;
  localparam code_t STEP_VERT  = 2'd2;
  localparam code_t STEP_EMPTY = 2'd3;

endpackage

### sv/affine_gap_alignment_unit.sv
// Top level of the affine gap alignment unit: sequence stores, score rows,
// traceback memory and one shared add/max unit under a small sequencer. Uses aga_pkg.
//
//  channel  dir  tdata fields (low bit up)         tuser       other
//  in_      in   symbol[7:0]                       func[1:0]   -
//  out_     out  step[1:0], score[9:2], pad        -           tlast = last
//
// A load writes its symbol into the A or B sequence store. A start fills m*n matrix cells,
// each a row read and then one pass of the shared add/max unit per cycle, then traces back
// at most m+n items (one empty item when both lengths are zero); inner items wait on a trace
// memory read and all wait on output stalls. The block is not ready from start until the last item
// is in the output register. Reset is synchronous and needs no clearing pass.
`include "affine_gap_alignment_unit_macros.svh"

module affine_gap_alignment_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol[7:0]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // step[1:0], score[9:2], zeros[15:10]
  output logic        out_tlast
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_H    = 4'd2;
  localparam logic [3:0] ST_V    = 4'd3;
  localparam logic [3:0] ST_T    = 4'd4;
  localparam logic [3:0] ST_B    = 4'd5;
  localparam logic [3:0] ST_TB   = 4'd6;
  localparam logic [3:0] ST_TBW  = 4'd7;

  localparam int LW = aga_pkg::LEN_W;
  localparam int IW = aga_pkg::IDX_W;

  logic [3:0]  state_r, state_nxt;
  logic [LW-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic [LW-1:0] m_r, m_nxt, n_r, n_nxt;
  logic [LW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [LW-1:0] im1, jm1;

  aga_pkg::score_t horiz_r, horiz_nxt, vert_r, vert_nxt, t_r, t_nxt;
  aga_pkg::score_t left_r, left_nxt, ul_r, ul_nxt, up_r, up_nxt;
  aga_pkg::score_t score_r, score_nxt;

  logic        out_valid_r, out_valid_nxt;
  aga_pkg::code_t out_step_r, out_step_nxt;
  logic [7:0]  out_score_r, out_score_nxt;
  logic        out_last_r, out_last_nxt;

  // Memories.
  logic [7:0]           seq_a_mem [aga_pkg::MAX_LEN];
  logic [7:0]           seq_b_mem [aga_pkg::MAX_LEN];
  aga_pkg::score_t      diag_mem  [aga_pkg::MAX_LEN];
  aga_pkg::score_t      vert_mem  [aga_pkg::MAX_LEN];
  aga_pkg::code_t       trace_mem [aga_pkg::MAX_LEN * aga_pkg::MAX_LEN];
  logic [7:0]           sym_a_rd, sym_b_rd;
  aga_pkg::score_t      diag_rd, vert_rd;
  aga_pkg::code_t       trace_rd;

  logic            in_acc;
  aga_pkg::code_t  in_func;
  logic [7:0]      in_sym;
  logic            we_a, we_b, row_we, trace_re, row_re;
  logic            out_free, out_load;
  aga_pkg::code_t  dir, tb_dir;

  // Shared add/max unit.
  aga_pkg::score_t  ua, ub, best, up_val, vup_val;
  aga_pkg::weight_t uka, ukb;
  aga_pkg::sum_t    sa, sb;

  assign in_func  = aga_pkg::code_t'(in_tuser);
  assign in_sym   = in_tdata;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign im1      = i_r - LW'(1);
  assign jm1      = j_r - LW'(1);

  assign we_a = in_acc && (in_func == aga_pkg::FUNC_LOAD_A) &&
                (len_a_r < LW'(aga_pkg::MAX_LEN));
  assign we_b = in_acc && (in_func == aga_pkg::FUNC_LOAD_B) &&
                (len_b_r < LW'(aga_pkg::MAX_LEN));
  assign row_re   = (state_r == ST_RD);
  assign row_we   = (state_r == ST_B);
  assign out_free = !out_valid_r || out_tready;
  assign trace_re = (state_r == ST_TB) && out_free && (i_r != '0) && (j_r != '0);

  // On the first row the upper neighbours come from the border, not the row store.
  assign up_val  = (i_r == LW'(1)) ? '0 : diag_rd;
  assign vup_val = (i_r == LW'(1)) ? aga_pkg::W_FORBID : vert_rd;

  always_comb begin
    unique case (state_r)
      ST_H: begin
        ua = horiz_r; uka = aga_pkg::W_EXTEND;
        ub = left_r;  ukb = aga_pkg::W_NEW_GAP;
      end
      ST_V: begin
        ua = vup_val; uka = aga_pkg::W_EXTEND;
        ub = up_val;  ukb = aga_pkg::W_NEW_GAP;
      end
      ST_T: begin
        ua = horiz_r; uka = aga_pkg::W_ZERO;
        ub = vert_r;  ukb = aga_pkg::W_ZERO;
      end
      default: begin
        ua  = ul_r;
        uka = (sym_a_rd == sym_b_rd) ? aga_pkg::W_MATCH : aga_pkg::W_MISMATCH;
        ub  = t_r;  ukb = aga_pkg::W_ZERO;
      end
    endcase
    sa   = {ua[aga_pkg::SCORE_W-1], ua} + aga_pkg::sum_t'(uka);
    sb   = {ub[aga_pkg::SCORE_W-1], ub} + aga_pkg::sum_t'(ukb);
    best = (sa > sb) ? sa[aga_pkg::SCORE_W-1:0] : sb[aga_pkg::SCORE_W-1:0];
  end

  always_comb begin
    priority if (best == horiz_r) begin
      dir = aga_pkg::STEP_HORIZ;
    end else if (best == vert_r) begin
      dir = aga_pkg::STEP_VERT;
    end else begin
      dir = aga_pkg::STEP_DIAG;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    horiz_nxt     = horiz_r;
    vert_nxt      = vert_r;
    t_nxt         = t_r;
    left_nxt      = left_r;
    ul_nxt        = ul_r;
    up_nxt        = up_r;
    score_nxt     = score_r;
    out_load      = 1'b0;
    tb_dir        = aga_pkg::STEP_EMPTY;
    out_step_nxt  = out_step_r;
    out_score_nxt = out_score_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (we_a) len_a_nxt = len_a_r + LW'(1);
        if (we_b) len_b_nxt = len_b_r + LW'(1);
        if (in_acc && (in_func == aga_pkg::FUNC_START)) begin
          m_nxt     = len_a_r;
          n_nxt     = len_b_r;
          len_a_nxt = '0;
          len_b_nxt = '0;
          score_nxt = '0;
          ul_nxt    = '0;
          left_nxt  = '0;
          horiz_nxt = aga_pkg::W_FORBID;
          if ((len_a_r == '0) || (len_b_r == '0)) begin
            i_nxt     = len_a_r;
            j_nxt     = len_b_r;
            state_nxt = ST_TB;
          end else begin
            i_nxt     = LW'(1);
            j_nxt     = LW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: state_nxt = ST_H;
      ST_H: begin
        horiz_nxt = best;
        state_nxt = ST_V;
      end
      ST_V: begin
        vert_nxt  = best;
        up_nxt    = up_val;
        state_nxt = ST_T;
      end
      ST_T: begin
        t_nxt     = best;
        state_nxt = ST_B;
      end
      ST_B: begin
        ul_nxt   = up_r;
        left_nxt = best;
        if (j_r == n_r) begin
          score_nxt = best;
          if (i_r == m_r) begin
            state_nxt = ST_TB;
          end else begin
            i_nxt     = i_r + LW'(1);
            j_nxt     = LW'(1);
            ul_nxt    = '0;
            left_nxt  = '0;
            horiz_nxt = aga_pkg::W_FORBID;
            state_nxt = ST_RD;
          end
        end else begin
          j_nxt     = j_r + LW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_TB: begin
        if (out_free) begin
          if ((i_r == '0) && (j_r == '0)) begin
            out_load = 1'b1;
            tb_dir   = aga_pkg::STEP_EMPTY;
          end else if (i_r == '0) begin
            out_load = 1'b1;
            tb_dir   = aga_pkg::STEP_HORIZ;
          end else if (j_r == '0) begin
            out_load = 1'b1;
            tb_dir   = aga_pkg::STEP_VERT;
          end else begin
            state_nxt = ST_TBW;
          end
        end
      end
      ST_TBW: begin
        out_load = 1'b1;
        tb_dir   = trace_rd;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      unique case (tb_dir)
        aga_pkg::STEP_HORIZ: j_nxt = j_r - LW'(1);
        aga_pkg::STEP_VERT:  i_nxt = i_r - LW'(1);
        aga_pkg::STEP_DIAG: begin
          i_nxt = i_r - LW'(1);
          j_nxt = j_r - LW'(1);
        end
        default: ;
      endcase
      out_step_nxt  = tb_dir;
      out_score_nxt = score_r[7:0];
      out_last_nxt  = (i_nxt == '0) && (j_nxt == '0);
      state_nxt     = out_last_nxt ? ST_IDLE : ST_TB;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r         <= m_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    horiz_r     <= horiz_nxt;
    vert_r      <= vert_nxt;
    t_r         <= t_nxt;
    left_r      <= left_nxt;
    ul_r        <= ul_nxt;
    up_r        <= up_nxt;
    score_r     <= score_nxt;
    out_step_r  <= out_step_nxt;
    out_score_r <= out_score_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_a) seq_a_mem[len_a_r[IW-1:0]] <= in_sym;
    if (row_re) sym_a_rd <= seq_a_mem[im1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_b) seq_b_mem[len_b_r[IW-1:0]] <= in_sym;
    if (row_re) sym_b_rd <= seq_b_mem[jm1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) diag_mem[jm1[IW-1:0]] <= best;
    if (row_re) diag_rd <= diag_mem[jm1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) vert_mem[jm1[IW-1:0]] <= vert_r;
    if (row_re) vert_rd <= vert_mem[jm1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) trace_mem[{im1[IW-1:0], jm1[IW-1:0]}] <= dir;
    if (trace_re) trace_rd <= trace_mem[{im1[IW-1:0], jm1[IW-1:0]}];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_score_r, out_step_r};
  assign out_tlast  = out_last_r;

  // The output register is only loaded when it is empty or being emptied.
  `AGA_ASSERT_IMP(a_out_no_overwrite, out_load, out_free, "result overwritten before taken")
  // After the final item of a run the sequencer is back at idle.
  `AGA_ASSERT_NXT(a_last_to_idle, out_load && out_last_nxt, state_r == ST_IDLE,
                  "sequencer not idle after final item")
  // Cell indices stay inside the loaded lengths while the matrices are filled.
  `AGA_ASSERT_IMP(a_cell_in_range,
                  (state_r == ST_RD) || (state_r == ST_B),
                  (i_r != '0) && (j_r != '0) && (i_r <= m_r) && (j_r <= n_r),
                  "cell index outside the loaded lengths")
  // Every traceback move other than the empty one shortens the remaining path.
  `AGA_ASSERT_NXT(a_tb_progress, out_load && (tb_dir != aga_pkg::STEP_EMPTY),
                  (7'(i_r) + 7'(j_r)) < (7'($past(i_r)) + 7'($past(j_r))),
                  "traceback made no progress")

endmodule
